// ===== hw/rtl/rsc_pkg.sv =====
// rsc_pkg: payload types, sequencer codes and fixed-point helpers of the ray/sphere unit
package rsc_pkg;

   localparam int ACC_W  = 136;  // wide accumulator: discriminant and root remainder
   localparam int OPD_W  = 68;   // signed operand carrier into the multiplier
   localparam int MAG_W  = 96;   // operand magnitude, three 32-bit limbs
   localparam int LIMB_W = 32;
   localparam int PROD_W = 64;
   localparam int DIV_W  = 96;   // divider remainder and divisor
   localparam int NUM_W  = 70;   // root numerator arithmetic

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CAST = 1'b1;

   localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   typedef struct packed {
      logic               operation;
      logic [1:0]         slot;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic [30:0]        radius;
      logic               material_in;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [30:0]        distance;
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic signed [31:0] hit_z;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic               material_out;
   } rsp_type;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b000000000001,
      ST_MUL   = 12'b000000000010,
      ST_DRAIN = 12'b000000000100,
      ST_POST  = 12'b000000001000,
      ST_NEXT  = 12'b000000010000,
      ST_SQRT  = 12'b000000100000,
      ST_NUM   = 12'b000001000000,
      ST_DIV   = 12'b000010000000,
      ST_BEST  = 12'b000100000000,
      ST_FIN   = 12'b001000000000,
      ST_NORM  = 12'b010000000000,
      ST_RESP  = 12'b100000000000
   } state_type;

   // what the multiply-accumulate pass is building
   typedef enum logic [4:0] {
      PH_A = 5'b00001,   // sum d*d
      PH_B = 5'b00010,   // sum oc*d
      PH_C = 5'b00100,   // sum oc*oc - r*r
      PH_D = 5'b01000,   // b*b - a*c
      PH_T = 5'b10000    // t*d for one axis
   } phase_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return SAT_MAX;
      end else if (v < -66'sd2147483648) begin
         return SAT_MIN;
      end
      return v[31:0];
   endfunction

   function automatic logic [MAG_W-1:0] mag68(input logic signed [OPD_W-1:0] v);
      logic [OPD_W-1:0] u;
      u = v[OPD_W-1] ? OPD_W'(-v) : OPD_W'(v);
      return {{(MAG_W-OPD_W){1'b0}}, u};
   endfunction

endpackage

// ===== hw/rtl/ray_sphere_closest_hit.sv =====
// ray_sphere_closest_hit: sphere table and closest-hit ray caster around one shared multiplier
// load: result is offered the cycle after the transfer; the next request waits until it is taken
// cast: sweeps every valid sphere, finishes the closest hit, then offers the result
//   the sweep is set by the limb schedule of the 32x32 multiplier, the 67-step square root
//   and the 31-step distance divide; one item is in flight at a time
// reset is synchronous: sequencer idle, no result pending, every table slot invalid
module ray_sphere_closest_hit
   import rsc_pkg::*;
#(
   parameter int SPHERES = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IW = (SPHERES > 1) ? $clog2(SPHERES) : 1;
   localparam int KW = $clog2(SPHERES + 1);

   // sphere table; payload is only read behind its valid bit
   logic signed [31:0] cen_x_ff [SPHERES];
   logic signed [31:0] cen_y_ff [SPHERES];
   logic signed [31:0] cen_z_ff [SPHERES];
   logic [30:0]        rad_ff   [SPHERES];
   logic               mat_ff   [SPHERES];
   logic [SPHERES-1:0] valid_ff, valid_in;

   // sequencer
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [1:0] term_ff, term_in;
   logic [1:0] li_ff, li_in;
   logic [1:0] lj_ff, lj_in;
   logic [1:0] j_ff, j_in;
   logic [KW-1:0] k_ff, k_in;

   // ray
   logic signed [31:0] o_ff [3];
   logic signed [31:0] d_ff [3];
   logic signed [31:0] o_in [3];
   logic signed [31:0] d_in [3];

   // multiplier pipeline and wide accumulator
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [2:0]        psh_ff, psh_in;
   logic              pneg_ff, pneg_in;
   logic              pv_ff, pv_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;

   // quadratic terms
   logic [63:0]        a_ff, a_in;
   logic signed [65:0] b_ff, b_in;
   logic signed [66:0] cq_ff, cq_in;

   // square root and divider
   logic [ACC_W-1:0] root_ff, root_in;
   logic [6:0]       scnt_ff, scnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [31:0]      quot_ff, quot_in;
   logic [4:0]       dcnt_ff, dcnt_in;
   logic             nneg_ff, nneg_in;
   logic             nsat_ff, nsat_in;

   // candidate and best hit so far
   logic [30:0]        q_ff, q_in;
   logic               found_ff, found_in;
   logic [30:0]        best_t_ff, best_t_in;
   logic signed [31:0] best_c_ff [3];
   logic signed [31:0] best_c_in [3];
   logic [30:0]        best_r_ff, best_r_in;
   logic               best_m_ff, best_m_in;

   rsp_type rsp_ff, rsp_in;

   // operand selection
   logic [IW-1:0]      kidx;
   logic signed [31:0] cen_sel [3];
   logic signed [32:0] oc_v [3];
   logic signed [31:0] d_t, d_j, o_j;
   logic signed [32:0] oc_t, oc_j;
   logic [30:0]        r_sel;
   logic signed [OPD_W-1:0] opx, opy;
   logic               op_xneg;
   logic [MAG_W-1:0]   mag_x, mag_y;
   logic [LIMB_W-1:0]  limb_x, limb_y;
   logic               mneg;
   logic [1:0]         last_term;
   logic [ACC_W-1:0]   acc_add;

   logic req_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

   assign kidx = k_ff[IW-1:0];

   // centre is the swept slot, or the winning sphere while the hit is finished
   always_comb begin
      if (phase_ff == PH_T) begin
         cen_sel[0] = best_c_ff[0];
         cen_sel[1] = best_c_ff[1];
         cen_sel[2] = best_c_ff[2];
         r_sel      = best_r_ff;
      end else begin
         cen_sel[0] = cen_x_ff[kidx];
         cen_sel[1] = cen_y_ff[kidx];
         cen_sel[2] = cen_z_ff[kidx];
         r_sel      = rad_ff[kidx];
      end
      for (int i = 0; i < 3; i++) begin
         oc_v[i] = {o_ff[i][31], o_ff[i]} - {cen_sel[i][31], cen_sel[i]};
      end
   end

   always_comb begin
      case (term_ff)
         2'd0: begin
            d_t  = d_ff[0];
            oc_t = oc_v[0];
         end
         2'd1: begin
            d_t  = d_ff[1];
            oc_t = oc_v[1];
         end
         default: begin
            d_t  = d_ff[2];
            oc_t = oc_v[2];
         end
      endcase
      case (j_ff)
         2'd0: begin
            d_j  = d_ff[0];
            o_j  = o_ff[0];
            oc_j = oc_v[0];
         end
         2'd1: begin
            d_j  = d_ff[1];
            o_j  = o_ff[1];
            oc_j = oc_v[1];
         end
         default: begin
            d_j  = d_ff[2];
            o_j  = o_ff[2];
            oc_j = oc_v[2];
         end
      endcase
   end

   // operand pair of the current product term
   always_comb begin
      opx       = '0;
      opy       = '0;
      op_xneg   = 1'b0;
      last_term = 2'd2;
      case (phase_ff)
         PH_A: begin
            opx = OPD_W'(d_t);
            opy = OPD_W'(d_t);
         end
         PH_B: begin
            opx = OPD_W'(oc_t);
            opy = OPD_W'(d_t);
         end
         PH_C: begin
            last_term = 2'd3;
            if (term_ff == 2'd3) begin
               opx     = {{(OPD_W-31){1'b0}}, r_sel};
               opy     = {{(OPD_W-31){1'b0}}, r_sel};
               op_xneg = 1'b1;
            end else begin
               opx = OPD_W'(oc_t);
               opy = OPD_W'(oc_t);
            end
         end
         PH_D: begin
            last_term = 2'd1;
            if (term_ff == 2'd1) begin
               opx     = {{(OPD_W-64){1'b0}}, a_ff};
               opy     = OPD_W'(cq_ff);
               op_xneg = 1'b1;
            end else begin
               opx = OPD_W'(b_ff);
               opy = OPD_W'(b_ff);
            end
         end
         PH_T: begin
            last_term = 2'd0;
            opx       = {{(OPD_W-31){1'b0}}, best_t_ff};
            opy       = OPD_W'(d_j);
         end
         default: begin
            last_term = 2'd2;
         end
      endcase
      mag_x = mag68(opx);
      mag_y = mag68(opy);
      mneg  = opx[OPD_W-1] ^ opy[OPD_W-1] ^ op_xneg;
      case (li_ff)
         2'd0:    limb_x = mag_x[31:0];
         2'd1:    limb_x = mag_x[63:32];
         default: limb_x = mag_x[95:64];
      endcase
      case (lj_ff)
         2'd0:    limb_y = mag_y[31:0];
         2'd1:    limb_y = mag_y[63:32];
         default: limb_y = mag_y[95:64];
      endcase
   end

   // registered partial product lands at its limb offset
   assign acc_add = {{(ACC_W-PROD_W){1'b0}}, prod_ff} << {psh_ff, 5'd0};

   always_comb begin
      logic [ACC_W-1:0]        bitv, trial;
      logic signed [NUM_W-1:0] bx, sx, n1, n2, nsel;
      logic                    n1pos, n2pos;
      logic [DIV_W-1:0]        numsh, a31;
      logic [DIV_W-1:0]        rem_sub;
      logic                    dge;
      logic signed [63:0]      td;
      logic signed [65:0]      hsum, numer, nmag;
      logic signed [33:0]      nval;
      logic signed [31:0]      hval, normv;

      state_in  = state_ff;
      phase_in  = phase_ff;
      term_in   = term_ff;
      li_in     = li_ff;
      lj_in     = lj_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      valid_in  = valid_ff;
      for (int i = 0; i < 3; i++) begin
         o_in[i]      = o_ff[i];
         d_in[i]      = d_ff[i];
         best_c_in[i] = best_c_ff[i];
      end
      prod_in   = prod_ff;
      psh_in    = psh_ff;
      pneg_in   = pneg_ff;
      pv_in     = 1'b0;
      acc_in    = acc_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      cq_in     = cq_ff;
      root_in   = root_ff;
      scnt_in   = scnt_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      quot_in   = quot_ff;
      dcnt_in   = dcnt_ff;
      nneg_in   = nneg_ff;
      nsat_in   = nsat_ff;
      q_in      = q_ff;
      found_in  = found_ff;
      best_t_in = best_t_ff;
      best_r_in = best_r_ff;
      best_m_in = best_m_ff;
      rsp_in    = rsp_ff;

      bitv    = {{(ACC_W-1){1'b0}}, 1'b1} << {scnt_ff, 1'b0};
      trial   = root_ff + bitv;
      bx      = NUM_W'(b_ff);
      sx      = {{(NUM_W-68){1'b0}}, root_ff[67:0]};
      n1      = -bx - sx;
      n2      = sx - bx;
      n1pos   = !n1[NUM_W-1] && (n1 != '0);
      n2pos   = !n2[NUM_W-1] && (n2 != '0);
      nsel    = n1pos ? n1 : n2;
      numsh   = {{(DIV_W-84){1'b0}}, nsel[67:0], 16'd0};
      a31     = {1'b0, a_ff, 31'd0};
      rem_sub = rem_ff - dvs_ff;
      dge     = (rem_ff >= dvs_ff);
      td      = acc_ff[63:0];
      hsum    = 66'(o_j) + 66'(td >>> 16);
      hval    = sat32(hsum);
      numer   = (66'(oc_j) <<< 16) + 66'(td);
      nmag    = numer[65] ? -numer : numer;
      nval    = nneg_ff ? (-34'(quot_ff) - 34'(rem_ff != '0)) : 34'(quot_ff);
      normv   = nsat_ff ? (nneg_ff ? SAT_MIN : SAT_MAX) : sat32(66'(nval));

      if (pv_ff) begin
         acc_in = pneg_ff ? (acc_ff - acc_add) : (acc_ff + acc_add);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.operation == OP_LOAD) begin
                  for (int i = 0; i < SPHERES; i++) begin
                     if (int'(req_data.slot) == i) begin
                        valid_in[i] = (req_data.radius != '0);
                     end
                  end
                  rsp_in   = '0;
                  state_in = ST_RESP;
               end else begin
                  o_in[0]  = req_data.point_x;
                  o_in[1]  = req_data.point_y;
                  o_in[2]  = req_data.point_z;
                  d_in[0]  = req_data.dir_x;
                  d_in[1]  = req_data.dir_y;
                  d_in[2]  = req_data.dir_z;
                  found_in = 1'b0;
                  phase_in = PH_A;
                  term_in  = 2'd0;
                  li_in    = 2'd0;
                  lj_in    = 2'd0;
                  acc_in   = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in = PROD_W'(limb_x) * PROD_W'(limb_y);
            psh_in  = {1'b0, li_ff} + {1'b0, lj_ff};
            pneg_in = mneg;
            pv_in   = 1'b1;
            if (lj_ff == 2'd2) begin
               lj_in = 2'd0;
               if (li_ff == 2'd2) begin
                  li_in = 2'd0;
                  if (term_ff == last_term) begin
                     state_in = ST_DRAIN;
                  end else begin
                     term_in = term_ff + 2'd1;
                  end
               end else begin
                  li_in = li_ff + 2'd1;
               end
            end else begin
               lj_in = lj_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_POST;
         end
         ST_POST: begin
            term_in = 2'd0;
            case (phase_ff)
               PH_A: begin
                  a_in = acc_ff[63:0];
                  k_in = '0;
                  // zero direction misses everything
                  state_in = (acc_ff == '0) ? ST_FIN : ST_NEXT;
               end
               PH_B: begin
                  b_in     = acc_ff[65:0];
                  acc_in   = '0;
                  phase_in = PH_C;
                  state_in = ST_MUL;
               end
               PH_C: begin
                  cq_in    = acc_ff[66:0];
                  acc_in   = '0;
                  phase_in = PH_D;
                  state_in = ST_MUL;
               end
               PH_D: begin
                  if (acc_ff[ACC_W-1]) begin
                     q_in     = '0;
                     state_in = ST_BEST;
                  end else begin
                     root_in  = '0;
                     scnt_in  = 7'd66;
                     state_in = ST_SQRT;
                  end
               end
               PH_T: begin
                  case (j_ff)
                     2'd0:    rsp_in.hit_x = hval;
                     2'd1:    rsp_in.hit_y = hval;
                     default: rsp_in.hit_z = hval;
                  endcase
                  nneg_in = numer[65];
                  if (nmag >= {3'd0, r_sel, 32'd0}) begin
                     nsat_in  = 1'b1;
                     state_in = ST_NORM;
                  end else begin
                     nsat_in  = 1'b0;
                     rem_in   = {{(DIV_W-66){1'b0}}, nmag};
                     dvs_in   = {{(DIV_W-62){1'b0}}, r_sel, 31'd0};
                     quot_in  = '0;
                     dcnt_in  = 5'd31;
                     state_in = ST_DIV;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_NEXT: begin
            if (k_ff == KW'(SPHERES)) begin
               state_in = ST_FIN;
            end else if (!valid_ff[kidx]) begin
               k_in = k_ff + KW'(1);
            end else begin
               phase_in = PH_B;
               term_in  = 2'd0;
               li_in    = 2'd0;
               lj_in    = 2'd0;
               acc_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_SQRT: begin
            if (acc_ff >= trial) begin
               acc_in  = acc_ff - trial;
               root_in = (root_ff >> 1) + bitv;
            end else begin
               root_in = root_ff >> 1;
            end
            if (scnt_ff == '0) begin
               state_in = ST_NUM;
            end else begin
               scnt_in = scnt_ff - 7'd1;
            end
         end
         ST_NUM: begin
            if (!n1pos && !n2pos) begin
               q_in     = '0;
               state_in = ST_BEST;
            end else if (numsh >= a31) begin
               q_in     = '1;
               state_in = ST_BEST;
            end else begin
               rem_in   = numsh;
               dvs_in   = {2'd0, a_ff, 30'd0};
               quot_in  = '0;
               dcnt_in  = 5'd30;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (dge) begin
               rem_in  = rem_sub;
               quot_in = {quot_ff[30:0], 1'b1};
            end else begin
               quot_in = {quot_ff[30:0], 1'b0};
            end
            dvs_in = dvs_ff >> 1;
            if (dcnt_ff == '0) begin
               if (phase_ff == PH_T) begin
                  state_in = ST_NORM;
               end else begin
                  q_in     = quot_in[30:0];
                  state_in = ST_BEST;
               end
            end else begin
               dcnt_in = dcnt_ff - 5'd1;
            end
         end
         ST_BEST: begin
            // strict compare keeps the lower slot on a tie
            if ((q_ff != '0) && (!found_ff || (q_ff < best_t_ff))) begin
               found_in     = 1'b1;
               best_t_in    = q_ff;
               best_c_in[0] = cen_x_ff[kidx];
               best_c_in[1] = cen_y_ff[kidx];
               best_c_in[2] = cen_z_ff[kidx];
               best_r_in    = rad_ff[kidx];
               best_m_in    = mat_ff[kidx];
            end
            k_in     = k_ff + KW'(1);
            state_in = ST_NEXT;
         end
         ST_FIN: begin
            rsp_in = '0;
            if (found_ff) begin
               rsp_in.hit          = 1'b1;
               rsp_in.distance     = best_t_ff;
               rsp_in.material_out = best_m_ff;
               j_in     = 2'd0;
               phase_in = PH_T;
               term_in  = 2'd0;
               li_in    = 2'd0;
               lj_in    = 2'd0;
               acc_in   = '0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_NORM: begin
            case (j_ff)
               2'd0:    rsp_in.normal_x = normv;
               2'd1:    rsp_in.normal_y = normv;
               default: rsp_in.normal_z = normv;
            endcase
            if (j_ff == 2'd2) begin
               state_in = ST_RESP;
            end else begin
               j_in     = j_ff + 2'd1;
               term_in  = 2'd0;
               li_in    = 2'd0;
               lj_in    = 2'd0;
               acc_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // table payload, written on a load transfer to a slot that exists
   always_ff @(posedge clock) begin
      if (req_take && (req_data.operation == OP_LOAD)) begin
         for (int i = 0; i < SPHERES; i++) begin
            if (int'(req_data.slot) == i) begin
               cen_x_ff[i] <= req_data.point_x;
               cen_y_ff[i] <= req_data.point_y;
               cen_z_ff[i] <= req_data.point_z;
               rad_ff[i]   <= req_data.radius;
               mat_ff[i]   <= req_data.material_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_A;
         valid_ff <= '0;
         pv_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
         pv_ff    <= pv_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff   <= term_in;
      li_ff     <= li_in;
      lj_ff     <= lj_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      for (int i = 0; i < 3; i++) begin
         o_ff[i]      <= o_in[i];
         d_ff[i]      <= d_in[i];
         best_c_ff[i] <= best_c_in[i];
      end
      prod_ff   <= prod_in;
      psh_ff    <= psh_in;
      pneg_ff   <= pneg_in;
      acc_ff    <= acc_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      cq_ff     <= cq_in;
      root_ff   <= root_in;
      scnt_ff   <= scnt_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      quot_ff   <= quot_in;
      dcnt_ff   <= dcnt_in;
      nneg_ff   <= nneg_in;
      nsat_ff   <= nsat_in;
      q_ff      <= q_in;
      best_t_ff <= best_t_in;
      best_r_ff <= best_r_in;
      best_m_ff <= best_m_in;
      rsp_ff    <= rsp_in;
   end

endmodule

// ===== hw/rtl/rsc_checker.sv =====
// rsc_checker: port-level checks of the ray/sphere unit, bound to the top level
module rsc_checker
   import rsc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // a pending result holds off the next transfer
   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result is pending");

   // a miss or a load carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |->
         (rsp_data.distance == '0 && rsp_data.material_out == 1'b0 &&
          rsp_data.hit_x == '0 && rsp_data.hit_y == '0 && rsp_data.hit_z == '0 &&
          rsp_data.normal_x == '0 && rsp_data.normal_y == '0 &&
          rsp_data.normal_z == '0))
      else $error("miss result with non-zero fields");

   // a hit lies strictly ahead of the origin
   a_hit_ahead: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.distance != '0))
      else $error("hit with zero distance");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind ray_sphere_closest_hit rsc_checker u_rsc_checker (.*);

// ===== tb/sv/ray_sphere_hit_checker.sv =====
// ray_sphere_hit_checker: watches both channels, predicts each result and compares it
`timescale 1ns / 100ps

module ray_sphere_hit_checker
   import rsc_pkg::*;
#(
   parameter int SPHERES = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      load_total,
   output int      cast_total,
   output int      hit_total
);

   typedef logic signed [199:0] wide_t;

   logic signed [31:0] centre_x [SPHERES];
   logic signed [31:0] centre_y [SPHERES];
   logic signed [31:0] centre_z [SPHERES];
   logic [31:0]        radius_tab [SPHERES];
   logic               material_tab [SPHERES];
   logic               slot_live [SPHERES];

   rsp_type expected_hits [$];
   int      mismatch_count;

   function automatic logic signed [31:0] clamp32(input wide_t v);
      if (v > wide_t'(64'sd2147483647)) begin
         return SAT_MAX;
      end else if (v < -wide_t'(64'sd2147483648)) begin
         return SAT_MIN;
      end
      return v[31:0];
   endfunction

   function automatic wide_t floor_sqrt(input wide_t v);
      wide_t root;
      wide_t cand;
      root = '0;
      for (int b = 66; b >= 0; b--) begin
         cand = root + (wide_t'(1) <<< b);
         if (cand * cand <= v) root = cand;
      end
      return root;
   endfunction

   // ray parameter of one sphere; zero means no hit
   function automatic logic [31:0] sphere_distance(input int k, input wide_t o [3],
                                                   input wide_t d [3]);
      wide_t oc [3];
      wide_t a, b, c, disc, s, n, num, r;
      oc[0] = o[0] - wide_t'(centre_x[k]);
      oc[1] = o[1] - wide_t'(centre_y[k]);
      oc[2] = o[2] - wide_t'(centre_z[k]);
      r = wide_t'(radius_tab[k]);
      a = '0;
      b = '0;
      c = '0;
      for (int j = 0; j < 3; j++) begin
         a = a + d[j] * d[j];
         b = b + oc[j] * d[j];
         c = c + oc[j] * oc[j];
      end
      c = c - r * r;
      if (a == 0) return '0;
      disc = b * b - a * c;
      if (disc < 0) return '0;
      s = floor_sqrt(disc);
      n = -b - s;
      // nearer root behind the origin: fall back to the farther one
      if (n <= 0) begin
         n = s - b;
         if (n <= 0) return '0;
      end
      num = n <<< 16;
      if (num >= (a <<< 31)) return 32'h7fffffff;
      return 32'(num / a);
   endfunction

   function automatic rsp_type predict_hit(input req_type q);
      rsp_type res;
      wide_t o [3];
      wide_t d [3];
      wide_t cen [3];
      wide_t td, v, r, quo;
      logic [31:0] t, best_t;
      int best;
      logic found;
      res = '0;
      if (q.operation == OP_LOAD) begin
         if (int'(q.slot) < SPHERES) begin
            centre_x[q.slot] = q.point_x;
            centre_y[q.slot] = q.point_y;
            centre_z[q.slot] = q.point_z;
            radius_tab[q.slot] = {1'b0, q.radius};
            material_tab[q.slot] = q.material_in;
            slot_live[q.slot] = (q.radius != 0);
         end
         return res;
      end
      o[0] = wide_t'(q.point_x);
      o[1] = wide_t'(q.point_y);
      o[2] = wide_t'(q.point_z);
      d[0] = wide_t'(q.dir_x);
      d[1] = wide_t'(q.dir_y);
      d[2] = wide_t'(q.dir_z);
      found = 1'b0;
      best = 0;
      best_t = '0;
      // strict compare keeps the lower slot on a tie
      for (int k = 0; k < SPHERES; k++) begin
         if (!slot_live[k]) continue;
         t = sphere_distance(k, o, d);
         if (t != 0 && (!found || t < best_t)) begin
            found = 1'b1;
            best_t = t;
            best = k;
         end
      end
      if (!found) return res;
      cen[0] = wide_t'(centre_x[best]);
      cen[1] = wide_t'(centre_y[best]);
      cen[2] = wide_t'(centre_z[best]);
      r = wide_t'(radius_tab[best]);
      res.hit = 1'b1;
      res.distance = best_t[30:0];
      res.material_out = material_tab[best];
      for (int j = 0; j < 3; j++) begin
         td = wide_t'(best_t) * d[j];
         v = (o[j] <<< 16) + td;
         case (j)
            0: res.hit_x = clamp32(v >>> 16);
            1: res.hit_y = clamp32(v >>> 16);
            default: res.hit_z = clamp32(v >>> 16);
         endcase
         v = ((o[j] - cen[j]) <<< 16) + td;
         quo = v / r;
         if (v % r != 0 && v < 0) quo = quo - 1;
         case (j)
            0: res.normal_x = clamp32(quo);
            1: res.normal_y = clamp32(quo);
            default: res.normal_z = clamp32(quo);
         endcase
      end
      return res;
   endfunction

   function automatic int field_diff(input string name, input logic [31:0] want,
                                     input logic [31:0] got, input logic show);
      if (want === got) return 0;
      if (show) $display("  %s expected %h actual %h", name, want, got);
      return 1;
   endfunction

   task automatic compare_hit(input rsp_type want, input rsp_type got);
      int bad;
      logic show;
      show = (mismatch_count < 10);
      bad = 0;
      if (want !== got && show) $display("mismatch at %0t", $realtime);
      bad += field_diff("hit", 32'(want.hit), 32'(got.hit), show);
      bad += field_diff("distance", 32'(want.distance), 32'(got.distance), show);
      bad += field_diff("hit_x", want.hit_x, got.hit_x, show);
      bad += field_diff("hit_y", want.hit_y, got.hit_y, show);
      bad += field_diff("hit_z", want.hit_z, got.hit_z, show);
      bad += field_diff("normal_x", want.normal_x, got.normal_x, show);
      bad += field_diff("normal_y", want.normal_y, got.normal_y, show);
      bad += field_diff("normal_z", want.normal_z, got.normal_z, show);
      bad += field_diff("material_out", 32'(want.material_out), 32'(got.material_out), show);
      if (bad != 0) begin
         mismatch_count++;
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_hits.delete();
         for (int k = 0; k < SPHERES; k++) begin
            centre_x[k] = '0;
            centre_y[k] = '0;
            centre_z[k] = '0;
            radius_tab[k] = '0;
            material_tab[k] = 1'b0;
            slot_live[k] = 1'b0;
         end
      end else begin
         // result transfer against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0) begin
               if (mismatch_count < 10) $display("unexpected result at %0t", $realtime);
               mismatch_count++;
               fail_count++;
            end else begin
               compare_hit(expected_hits.pop_front(), rsp_data);
            end
         end
         if (req_valid && !req_stall) begin
            expected_hits.push_back(predict_hit(req_data));
            if (req_data.operation == OP_LOAD) begin
               load_total++;
            end else begin
               cast_total++;
               if (expected_hits[$].hit) hit_total++;
            end
         end
      end
      pending_count = expected_hits.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
      load_total = 0;
      cast_total = 0;
      hit_total = 0;
      mismatch_count = 0;
   end

endmodule

// ===== tb/sv/tb_ray_sphere_closest_hit.sv =====
// tb_ray_sphere_closest_hit: stimulus, handshake pacing and verdict for the ray/sphere unit
`timescale 1ns / 100ps

module tb_ray_sphere_closest_hit
   import rsc_pkg::*;
();

   localparam int  SPHERES     = 4;
   localparam int  UNIT        = 65536;   // 1.0 in Q16.16
   localparam int  PHASE_ITEMS = 200;
   localparam longint CYCLE_LIMIT = 6000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int load_total;
   int cast_total;
   int hit_total;

   // percentage of cycles in which each side holds off
   int send_idle_pct;
   int recv_idle_pct;
   longint cycle_count;

   // stimulus-side copy of where spheres were put, used to aim rays
   int aim_x [SPHERES];
   int aim_y [SPHERES];
   int aim_z [SPHERES];

   ray_sphere_closest_hit #(.SPHERES(SPHERES)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   ray_sphere_hit_checker #(.SPHERES(SPHERES)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .load_total   (load_total),
      .cast_total   (cast_total),
      .hit_total    (hit_total)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // receiver back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      if (!reset) rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
   end

   function automatic req_type sphere_load(input logic [1:0] slot, input int cx, input int cy,
                                           input int cz, input logic [30:0] rad,
                                           input logic mat);
      req_type q;
      q = '0;
      q.operation = OP_LOAD;
      q.slot = slot;
      q.point_x = cx;
      q.point_y = cy;
      q.point_z = cz;
      q.radius = rad;
      q.material_in = mat;
      return q;
   endfunction

   function automatic req_type ray_cast(input int ox, input int oy, input int oz,
                                        input int dx, input int dy, input int dz);
      req_type q;
      q = '0;
      q.operation = OP_CAST;
      q.point_x = ox;
      q.point_y = oy;
      q.point_z = oz;
      q.dir_x = dx;
      q.dir_y = dy;
      q.dir_z = dz;
      return q;
   endfunction

   function automatic int spread(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // one transfer on the request side, with random hold-off before it
   task automatic send_item(input req_type q);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data = q;
      if (q.operation == OP_LOAD && int'(q.slot) < SPHERES) begin
         aim_x[q.slot] = q.point_x;
         aim_y[q.slot] = q.point_y;
         aim_z[q.slot] = q.point_z;
      end
      // inputs are steady until the next rising edge, so stall read now holds there
      #1;
      while (req_stall) begin
         @(negedge clock);
         #1;
      end
      @(posedge clock);
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // hold the sender until every expected result has come back
   task automatic wait_drained();
      drop_valid();
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic random_item();
      int pick;
      int k;
      int ox;
      int oy;
      int oz;
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, SPHERES - 1);
      if (pick < 20) begin
         // sensible sphere, now and then a zero radius that disables the slot
         send_item(sphere_load(2'(k), spread(16 * UNIT), spread(16 * UNIT), spread(16 * UNIT),
                               ($urandom_range(0, 19) == 0) ? 31'd0
                                  : 31'($urandom_range(UNIT / 4, 6 * UNIT)),
                               1'($urandom)));
      end else if (pick < 80) begin
         // ray aimed near a loaded sphere, so most of these hit
         ox = spread(16 * UNIT);
         oy = spread(16 * UNIT);
         oz = spread(16 * UNIT);
         send_item(ray_cast(ox, oy, oz,
                            aim_x[k] - ox + spread(2 * UNIT),
                            aim_y[k] - oy + spread(2 * UNIT),
                            aim_z[k] - oz + spread(2 * UNIT)));
      end else if (pick < 92) begin
         send_item(ray_cast($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      end else begin
         send_item(sphere_load(2'($urandom), $urandom, $urandom, $urandom,
                               31'($urandom), 1'($urandom)));
      end
   endtask

   initial begin
      cycle_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 19;
      recv_idle_pct = 85;
      for (int k = 0; k < SPHERES; k++) begin
         aim_x[k] = 0;
         aim_y[k] = 0;
         aim_z[k] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table: any ray misses
      send_item(ray_cast(0, 0, 0, UNIT, 0, 0));
      // two identical spheres ahead on +x, tie goes to slot 0
      send_item(sphere_load(2'd0, 10 * UNIT, 0, 0, 31'(2 * UNIT), 1'b0));
      send_item(sphere_load(2'd1, 10 * UNIT, 0, 0, 31'(2 * UNIT), 1'b1));
      send_item(ray_cast(0, 0, 0, UNIT, 0, 0));
      // nearer sphere in slot 2 wins over the tie pair
      send_item(sphere_load(2'd2, 5 * UNIT, UNIT / 2, 0, 31'(UNIT), 1'b1));
      send_item(ray_cast(0, 0, 0, UNIT, 0, 0));
      // origin inside a sphere, only the farther root is in front
      send_item(ray_cast(10 * UNIT, 0, 0, 0, UNIT, 0));
      // sphere behind the ray and a ray pointing away: misses
      send_item(ray_cast(0, 0, 0, -UNIT, 0, 0));
      send_item(ray_cast(0, 5 * UNIT, 0, 0, UNIT, 0));
      // zero direction is never a hit
      send_item(ray_cast(0, 0, 0, 0, 0, 0));
      // tiny direction against a far sphere: distance saturates
      send_item(sphere_load(2'd3, 0, 0, 30000 * UNIT, 31'h7fffffff, 1'b1));
      send_item(ray_cast(0, 0, 0, 0, 0, 1));
      // extreme coordinates and directions
      send_item(ray_cast(32'sh80000000, 32'sh80000000, 32'sh80000000,
                         32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
      send_item(ray_cast(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                         32'sh80000000, 32'sh80000000, 32'sh80000000));
      send_item(ray_cast(32'sh7fffffff, 0, 32'sh80000000, 32'sh80000000, 1, 32'sh7fffffff));
      send_item(sphere_load(2'd2, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                            31'h7fffffff, 1'b0));
      send_item(ray_cast(0, 0, 0, -1, 1, -1));
      // zero radius switches slot 3 off
      send_item(sphere_load(2'd3, 0, 0, 0, 31'd0, 1'b1));
      send_item(ray_cast(0, 0, -4 * UNIT, 0, 0, UNIT));
      send_item(sphere_load(2'd2, 5 * UNIT, UNIT / 2, 0, 31'd1, 1'b1));
      send_item(ray_cast(0, UNIT / 2, 0, UNIT, 0, 0));
      wait_drained();

      // three paced phases, each drained before the next
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 85;
            end
            1: begin
               send_idle_pct = 85;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) random_item();
         wait_drained();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d loads and %0d casts, %0d of them hits", load_total, cast_total,
               hit_total);
      $display("random part ran with sender-heavy, receiver-heavy and free pacing");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d failing results", fail_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
